### hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256 hash core.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  function automatic word_t rotr(input word_t x, input int unsigned k);
    rotr = (x >> k) | (x << (32 - k));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### hdl/sha256_hash_core.sv
// ----------------------------------------------------------------------------
// sha256_hash_core
// Byte-serial SHA-256 hasher with one shared round unit.
//
//   channel  dir  fields                                 handshake
//   input    in   data_byte, byte_valid, message_end     in_valid / in_stall
//   output   out  digest_word, word_index, last_word     out_valid / out_stall
//
// The item that completes a 64-byte block adds 64 rounds through the single
// round unit and one chain update. An end item adds its padding bytes (up to
// 72 over two blocks), the compressions those bytes complete, and eight digest
// items, h0 first. Reset is synchronous and restores the initial hash values;
// in_stall stays high while padding, compressing or delivering the digest, and
// a stall on the output holds the current digest item.
// ----------------------------------------------------------------------------
module sha256_hash_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic        pad_active;
  logic [5:0]  fill_level;
  logic [5:0]  round_index;
  logic [63:0] byte_count;
  logic [2:0]  out_index;
  word_t       chain [8];
  word_t       win [16];
  word_t       va, vb, vc, vd, ve, vf, vg, vh;

  logic        in_accept;
  logic        put_en;
  logic [7:0]  put_byte;
  logic        len_now;
  logic [63:0] len_bits;
  logic [63:0] len_shift;
  logic [7:0]  pad_byte;
  logic [1:0]  phase_next;
  word_t       w_cur;
  word_t       t1;
  word_t       t2;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign len_bits  = {byte_count[60:0], 3'b000};
  assign len_now   = (phase == PH_LEN) || ((phase == PH_ZERO) && (fill_level == LEN_OFFSET));
  assign len_shift = len_bits >> {(3'd7 - fill_level[2:0]), 3'b000};

  always_comb begin
    unique case (phase)
      PH_MARK: begin
        pad_byte   = PAD_MARK;
        phase_next = PH_ZERO;
      end
      PH_ZERO: begin
        pad_byte   = len_now ? len_shift[7:0] : 8'h00;
        phase_next = len_now ? PH_LEN : PH_ZERO;
      end
      default: begin
        pad_byte   = len_shift[7:0];
        phase_next = PH_LEN;
      end
    endcase
  end

  always_comb begin
    put_en   = (state == ST_PAD) || (in_accept && byte_valid);
    put_byte = (state == ST_PAD) ? pad_byte : data_byte;
  end

  always_comb begin
    if (round_index[5:4] == 2'b00) begin
      w_cur = win[0];
    end else begin
      w_cur = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    end
    t1 = vh + big_sigma1(ve) + ((ve & vf) ^ (~ve & vg)) + ROUND_K[round_index] + w_cur;
    t2 = big_sigma0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  assign out_valid   = (state == ST_OUT);
  assign digest_word = chain[out_index];
  assign word_index  = out_index;
  assign last_word   = (out_index == 3'd7);

  // message bytes and schedule words share one shift line
  always_ff @(posedge clk) begin
    if (put_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i + 1][31:24]};
      end
      win[15] <= {win[15][23:0], put_byte};
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en && (fill_level == 6'd63)) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
      vf <= chain[5];
      vg <= chain[6];
      vh <= chain[7];
    end else if (state == ST_ROUND) begin
      vh <= vg;
      vg <= vf;
      vf <= ve;
      ve <= vd + t1;
      vd <= vc;
      vc <= vb;
      vb <= va;
      va <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_MARK;
      pad_active  <= 1'b0;
      fill_level  <= '0;
      round_index <= '0;
      byte_count  <= '0;
      out_index   <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= IV[i];
      end
    end else begin
      if (put_en) begin
        fill_level <= fill_level + 6'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            pad_active <= message_end;
            phase      <= PH_MARK;
            if (byte_valid) begin
              byte_count <= byte_count + 64'd1;
            end
            if (byte_valid && (fill_level == 6'd63)) begin
              state <= ST_ROUND;
            end else if (message_end) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          phase <= phase_next;
          if (fill_level == 6'd63) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          round_index <= round_index + 6'd1;
          if (round_index == 6'd63) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
          chain[5] <= chain[5] + vf;
          chain[6] <= chain[6] + vg;
          chain[7] <= chain[7] + vh;
          if (pad_active && (phase == PH_LEN)) begin
            state     <= ST_OUT;
            out_index <= '0;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_index <= out_index + 3'd1;
            if (out_index == 3'd7) begin
              state      <= ST_IDLE;
              pad_active <= 1'b0;
              phase      <= PH_MARK;
              byte_count <= '0;
              fill_level <= '0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= IV[i];
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
